// File: hdl/tlob_pkg.sv
// ----------------------------------------------------------------------------
// tlob_pkg
// Shared types and constants for the tiered limit order book.
// ----------------------------------------------------------------------------
`default_nettype none

package tlob_pkg;

  localparam int NUM_TIERS_DEF      = 64;
  localparam int TIER_WIDTH_DEF     = 64;
  localparam int SLOTS_PER_TIER_DEF = 16;

  localparam int DATA_W    = 32;
  localparam int ROW_W     = 16;
  localparam int SLOT_W    = 4;
  localparam int DIV_SHIFT = 26;

  localparam int IN_TDATA_W  = 96;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 96;
  localparam int OUT_TUSER_W = 1;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_CANCEL = 2'd1,
    REQ_REDUCE = 2'd2,
    REQ_QUERY  = 2'd3
  } req_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLR,
    OP_LOAD,
    OP_DIV1,
    OP_DIV2,
    OP_ROW_RD,
    OP_PICK,
    OP_LSCAN,
    OP_QSCAN,
    OP_INS_WR,
    OP_ENT_RD,
    OP_MOD_WR,
    OP_OUT
  } op_t;

  typedef struct packed {
    logic clr_done;
    logic neg;
    logic side_full;
    logic scan_done;
    logic hit;
    req_t req;
  } status_t;

endpackage

`default_nettype wire

// File: hdl/tlob_dp.sv
// ----------------------------------------------------------------------------
// tlob_dp
// Datapath: slot memories, location table, tier divider, scan engine and
// result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module tlob_dp import tlob_pkg::*; #(
  parameter int NUM_TIERS      = NUM_TIERS_DEF,
  parameter int TIER_WIDTH     = TIER_WIDTH_DEF,
  parameter int SLOTS_PER_TIER = SLOTS_PER_TIER_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire op_t                    op,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  input  wire logic [IN_TUSER_W-1:0]  in_tuser,
  output status_t                     st,
  output logic      [OUT_TDATA_W-1:0] out_tdata,
  output logic      [OUT_TUSER_W-1:0] out_tuser
);

  localparam int TS    = NUM_TIERS * SLOTS_PER_TIER;
  localparam int PW    = $clog2(TS);
  localparam int CW    = $clog2(TS + 1);
  localparam int TW    = (NUM_TIERS > 1) ? $clog2(NUM_TIERS) : 1;
  localparam int LIMIT = NUM_TIERS * TIER_WIDTH;
  localparam int QW    = DIV_SHIFT + 1;
  localparam int PRW   = DIV_SHIFT + QW;
  localparam int RW    = QW + 17;
  localparam logic [QW-1:0] RECIP = QW'((1 << DIV_SHIFT) / TIER_WIDTH);

  typedef struct packed {
    logic              v;
    logic [DATA_W-1:0] key;
    logic [PW-1:0]     place;
    logic [TW-1:0]     tier;
    logic [SLOT_W-1:0] slot;
  } loc_t;

  logic [ROW_W-1:0]  act_mem   [NUM_TIERS];
  logic [DATA_W-1:0] price_mem [TS];
  logic [DATA_W-1:0] vol_mem   [TS];
  loc_t              loc_mem   [TS];

  req_t              req_r;
  logic [DATA_W-1:0] id_r, price_r, qty_r;
  logic              side_r;
  logic [QW-1:0]     q_r;
  logic [TW-1:0]     tier_r;
  logic [ROW_W-1:0]  row_rd_r, cur_row_r;
  logic [DATA_W-1:0] price_rd_r, vol_rd_r;
  loc_t              loc_rd_r;
  logic [SLOT_W-1:0] pick_slot_r;
  logic [PW-1:0]     place_r;
  logic [CW-1:0]     scan_cnt_r;
  logic [TW-1:0]     q_tier_r;
  logic [SLOT_W-1:0] q_slot_r, d_slot_r;
  logic              d_v_r;
  logic [PW-1:0]     d_addr_r;
  logic              hit_r, free_v_r;
  logic [PW-1:0]     ent_idx_r, ent_place_r, free_idx_r;
  logic [TW-1:0]     ent_tier_r;
  logic [SLOT_W-1:0] ent_slot_r;
  logic              acc_r, have_bid_r, have_ask_r;
  logic [DATA_W-1:0] rem_r, bid_r, ask_r;
  logic              out_acc_r;
  logic [DATA_W-1:0] out_rem_r, out_bid_r, out_ask_r;

  logic [TW-1:0]     row_raddr;
  logic              act_we, loc_we, pv_we, vol_we;
  logic [TW-1:0]     act_waddr;
  logic [ROW_W-1:0]  act_wdata;
  logic [PW-1:0]     loc_waddr, vol_waddr;
  loc_t              loc_wdata;
  logic [DATA_W-1:0] vol_wdata;
  logic              pick_found;
  logic [SLOT_W-1:0] pick_slot;
  logic [PRW-1:0]    prod;
  logic [RW-1:0]     qt, ext_p;
  logic              bump, big;
  logic              is_cancel, red_ok, free_now, scan_issue, qd_act;
  logic [DATA_W-1:0] vol_left;
  logic [PW-1:0]     scan_addr;

  assign scan_addr  = scan_cnt_r[PW-1:0];
  assign scan_issue = (scan_cnt_r < CW'(TS));
  assign is_cancel  = (req_r == REQ_CANCEL);
  assign red_ok     = (vol_rd_r >= qty_r);
  assign vol_left   = vol_rd_r - qty_r;
  assign free_now   = is_cancel || (red_ok && (vol_left == '0));
  assign qd_act     = d_v_r && row_rd_r[d_slot_r];

  // tier = price / TIER_WIDTH via reciprocal estimate plus one correction, clamped to the top tier at or above LIMIT
  assign prod  = PRW'(price_r[DIV_SHIFT-1:0]) * PRW'(RECIP);
  assign ext_p = RW'(price_r[DIV_SHIFT-1:0]);
  assign qt    = RW'(q_r) * RW'(TIER_WIDTH);
  assign bump  = (ext_p >= qt + RW'(TIER_WIDTH));
  assign big   = (price_r >= DATA_W'(LIMIT));

  // row_rd_r holds the insert tier's row from the pick cycle on
  always_comb begin
    pick_found = 1'b0;
    pick_slot  = '0;
    for (int s = 0; s < SLOTS_PER_TIER; s++) begin
      if (!pick_found && (s[0] == side_r) && !row_rd_r[s]) begin
        pick_found = 1'b1;
        pick_slot  = SLOT_W'(s);
      end
    end
  end

  always_comb begin
    case (op)
      OP_QSCAN:  row_raddr = q_tier_r;
      OP_ENT_RD: row_raddr = ent_tier_r;
      default:   row_raddr = tier_r;
    endcase
  end

  always_comb begin
    act_we    = 1'b0;
    act_waddr = tier_r;
    act_wdata = '0;
    loc_we    = 1'b0;
    loc_waddr = ent_idx_r;
    loc_wdata = '0;
    pv_we     = 1'b0;
    vol_we    = 1'b0;
    vol_waddr = place_r;
    vol_wdata = qty_r;
    case (op)
      OP_CLR: begin
        act_we    = scan_cnt_r < CW'(NUM_TIERS);
        act_waddr = scan_cnt_r[TW-1:0];
        loc_we    = scan_issue;
        loc_waddr = scan_addr;
      end
      OP_INS_WR: begin
        act_we    = 1'b1;
        act_wdata = cur_row_r | (ROW_W'(1) << pick_slot_r);
        pv_we     = 1'b1;
        vol_we    = 1'b1;
        loc_we    = hit_r || free_v_r;
        loc_waddr = hit_r ? ent_idx_r : free_idx_r;
        loc_wdata = '{v: 1'b1, key: id_r, place: place_r, tier: tier_r,
                      slot: pick_slot_r};
      end
      OP_MOD_WR: begin
        act_we    = free_now;
        act_waddr = ent_tier_r;
        act_wdata = row_rd_r & ~(ROW_W'(1) << ent_slot_r);
        loc_we    = free_now;
        vol_we    = !is_cancel && red_ok;
        vol_waddr = ent_place_r;
        vol_wdata = vol_left;
      end
      default: ;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    row_rd_r   <= act_mem[row_raddr];
    price_rd_r <= price_mem[scan_addr];
    vol_rd_r   <= vol_mem[ent_place_r];
    loc_rd_r   <= loc_mem[scan_addr];
    if (act_we) begin
      act_mem[act_waddr] <= act_wdata;
    end
    if (loc_we) begin
      loc_mem[loc_waddr] <= loc_wdata;
    end
    if (pv_we) begin
      price_mem[place_r] <= price_r;
    end
    if (vol_we) begin
      vol_mem[vol_waddr] <= vol_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_cnt_r <= '0;
      d_v_r      <= 1'b0;
      hit_r      <= 1'b0;
      free_v_r   <= 1'b0;
    end else begin
      d_v_r <= 1'b0;
      case (op)
        OP_CLR: begin
          if (scan_issue) begin
            scan_cnt_r <= scan_cnt_r + 1'b1;
          end
        end
        OP_LOAD: begin
          req_r      <= req_t'(in_tuser[1:0]);
          side_r     <= in_tuser[2];
          id_r       <= in_tdata[31:0];
          price_r    <= in_tdata[63:32];
          qty_r      <= in_tdata[95:64];
          scan_cnt_r <= '0;
          q_tier_r   <= '0;
          q_slot_r   <= '0;
          hit_r      <= 1'b0;
          free_v_r   <= 1'b0;
          acc_r      <= (req_t'(in_tuser[1:0]) == REQ_QUERY);
          rem_r      <= '0;
          bid_r      <= '0;
          ask_r      <= '0;
          have_bid_r <= 1'b0;
          have_ask_r <= 1'b0;
        end
        OP_DIV1: q_r <= prod[PRW-1:DIV_SHIFT];
        OP_DIV2: tier_r <= big ? TW'(NUM_TIERS - 1) : TW'(q_r + QW'(bump));
        OP_ROW_RD: ;
        OP_PICK: begin
          cur_row_r   <= row_rd_r;
          pick_slot_r <= pick_slot;
          place_r     <= PW'(PW'(tier_r) * PW'(SLOTS_PER_TIER) + PW'(pick_slot));
        end
        OP_LSCAN: begin
          if (scan_issue) begin
            scan_cnt_r <= scan_cnt_r + 1'b1;
            d_v_r      <= 1'b1;
            d_addr_r   <= scan_addr;
          end
          if (d_v_r && !hit_r) begin
            if (loc_rd_r.v && (loc_rd_r.key == id_r)) begin
              hit_r       <= 1'b1;
              ent_idx_r   <= d_addr_r;
              ent_place_r <= loc_rd_r.place;
              ent_tier_r  <= loc_rd_r.tier;
              ent_slot_r  <= loc_rd_r.slot;
            end
            if (!loc_rd_r.v && !free_v_r) begin
              free_v_r   <= 1'b1;
              free_idx_r <= d_addr_r;
            end
          end
        end
        OP_QSCAN: begin
          if (scan_issue) begin
            scan_cnt_r <= scan_cnt_r + 1'b1;
            d_v_r      <= 1'b1;
            d_slot_r   <= q_slot_r;
            if (q_slot_r == SLOT_W'(SLOTS_PER_TIER - 1)) begin
              q_slot_r <= '0;
              q_tier_r <= q_tier_r + 1'b1;
            end else begin
              q_slot_r <= q_slot_r + 1'b1;
            end
          end
          if (qd_act) begin
            if (!d_slot_r[0]) begin
              if (!have_bid_r || ($signed(price_rd_r) > $signed(bid_r))) begin
                bid_r      <= price_rd_r;
                have_bid_r <= 1'b1;
              end
            end else begin
              if (!have_ask_r || ($signed(price_rd_r) < $signed(ask_r))) begin
                ask_r      <= price_rd_r;
                have_ask_r <= 1'b1;
              end
            end
          end
        end
        OP_INS_WR: acc_r <= 1'b1;
        OP_MOD_WR: begin
          if (is_cancel) begin
            acc_r <= 1'b1;
            rem_r <= vol_rd_r;
          end else if (red_ok) begin
            acc_r <= 1'b1;
          end
        end
        OP_OUT: begin
          out_acc_r <= acc_r;
          out_rem_r <= rem_r;
          out_bid_r <= bid_r;
          out_ask_r <= ask_r;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    st.clr_done  = (scan_cnt_r == CW'(TS));
    st.neg       = price_r[DATA_W-1];
    st.side_full = !pick_found;
    st.scan_done = hit_r || (!scan_issue && !d_v_r);
    st.hit       = hit_r;
    st.req       = req_r;
  end

  assign out_tdata = {out_ask_r, out_bid_r, out_rem_r};
  assign out_tuser = out_acc_r;

  a_ins_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    op == OP_INS_WR |-> !cur_row_r[pick_slot_r])
    else $error("insert writes an occupied slot");

  a_entry_active: assert property (@(posedge clk) disable iff (!rst_n)
    op == OP_MOD_WR |-> row_rd_r[ent_slot_r])
    else $error("location entry points at an inactive slot");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    scan_cnt_r <= CW'(TS))
    else $error("scan counter out of range");

endmodule

`default_nettype wire

// File: hdl/tlob_ctrl.sv
// ----------------------------------------------------------------------------
// tlob_ctrl
// Request sequencer: issues datapath operations and runs the handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module tlob_ctrl import tlob_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_tvalid,
  output logic         in_tready,
  output logic         out_tvalid,
  input  wire logic    out_tready,
  input  wire status_t st,
  output op_t          op
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_DIV1, S_DIV2, S_ROW_RD, S_PICK,
    S_INS_SCAN, S_INS_WR, S_LOOK_SCAN, S_ENT_RD, S_MOD_WR, S_QSCAN, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    op            = OP_NONE;
    unique case (state_r)
      S_CLEAR: begin
        op = OP_CLR;
        if (st.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          op        = OP_LOAD;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (st.req)
          REQ_INSERT:             state_nxt = st.neg ? S_DONE : S_DIV1;
          REQ_CANCEL, REQ_REDUCE: state_nxt = S_LOOK_SCAN;
          REQ_QUERY:              state_nxt = S_QSCAN;
          default:                state_nxt = S_DONE;
        endcase
      end
      S_DIV1: begin
        op        = OP_DIV1;
        state_nxt = S_DIV2;
      end
      S_DIV2: begin
        op        = OP_DIV2;
        state_nxt = S_ROW_RD;
      end
      S_ROW_RD: begin
        op        = OP_ROW_RD;
        state_nxt = S_PICK;
      end
      S_PICK: begin
        op        = OP_PICK;
        state_nxt = S_INS_SCAN;
      end
      S_INS_SCAN: begin
        // a full side is flagged combinationally from the latched tier row
        if (st.side_full) begin
          state_nxt = S_DONE;
        end else begin
          op = OP_LSCAN;
          if (st.scan_done) state_nxt = S_INS_WR;
        end
      end
      S_INS_WR: begin
        op        = OP_INS_WR;
        state_nxt = S_DONE;
      end
      S_LOOK_SCAN: begin
        op = OP_LSCAN;
        if (st.scan_done) state_nxt = st.hit ? S_ENT_RD : S_DONE;
      end
      S_ENT_RD: begin
        op        = OP_ENT_RD;
        state_nxt = S_MOD_WR;
      end
      S_MOD_WR: begin
        op        = OP_MOD_WR;
        state_nxt = S_DONE;
      end
      S_QSCAN: begin
        op = OP_QSCAN;
        if (st.scan_done) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          op            = OP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_done_emits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && out_free |=> out_valid_r)
    else $error("finished request produced no result");

  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == S_DISPATCH)
    else $error("accepted request not dispatched");

endmodule

`default_nettype wire

// File: hdl/tiered_limit_order_book.sv
// Insert: load, dispatch, divide, tier row read, slot pick, a location scan
// of up to TS entries (TS = NUM_TIERS*SLOTS_PER_TIER, 1024 at defaults) and
// the write; cancel and reduce: scan, entry read, write; query: a scan of all
// slots; a result may wait on out_tready. One request is in flight at a time;
// the single-port location table and slot memories, read one entry per cycle,
// set the rate. Reset is synchronous, active low; clearing precedes requests.
// ----------------------------------------------------------------------------
// tiered_limit_order_book
// Price-tiered order book with insert, cancel, reduce and top-of-book query.
// ----------------------------------------------------------------------------
`default_nettype none

module tiered_limit_order_book import tlob_pkg::*; #(
  parameter int NUM_TIERS      = NUM_TIERS_DEF,
  parameter int TIER_WIDTH     = TIER_WIDTH_DEF,
  parameter int SLOTS_PER_TIER = SLOTS_PER_TIER_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // req_id[31:0], price[63:32], quantity[95:64]
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // req_type[1:0], side[2]
  input  wire logic [IN_TUSER_W-1:0]  in_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // removed_volume[31:0], top_bid[63:32], top_ask[95:64]
  output logic      [OUT_TDATA_W-1:0] out_tdata,
  // accepted[0]
  output logic      [OUT_TUSER_W-1:0] out_tuser
);

  op_t     op;
  status_t st;

  tlob_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .st         (st),
    .op         (op)
  );

  tlob_dp #(
    .NUM_TIERS      (NUM_TIERS),
    .TIER_WIDTH     (TIER_WIDTH),
    .SLOTS_PER_TIER (SLOTS_PER_TIER)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .st        (st),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

`default_nettype wire
